### rtl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer package
// Gesture codes, tracking mode codes, register indexes and time constants.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // Gesture codes carried on the result word.
    localparam logic [2:0] GEST_LONG_PRESS  = 3'd0;
    localparam logic [2:0] GEST_TAP         = 3'd1;
    localparam logic [2:0] GEST_SWIPE_LEFT  = 3'd2;
    localparam logic [2:0] GEST_SWIPE_RIGHT = 3'd3;
    localparam logic [2:0] GEST_SWIPE_UP    = 3'd4;
    localparam logic [2:0] GEST_SWIPE_DOWN  = 3'd5;

    // Tracking mode codes. The fourth code is never entered and acts as idle.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_TRACK = 2'd1;
    localparam logic [1:0] MODE_FIRED = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TAP_MAX_DIST    = 3'd0;
    localparam logic [2:0] REG_TAP_MAX_TIME_MS = 3'd1;
    localparam logic [2:0] REG_SWIPE_MIN_DIST  = 3'd2;
    localparam logic [2:0] REG_LONG_PRESS_MS   = 3'd3;
    localparam logic [2:0] REG_LONG_PRESS_DIST = 3'd4;
    localparam logic [2:0] REG_SCREEN_WIDTH    = 3'd5;
    localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd6;

    localparam int CFG_DATA_BITS = 16;
    localparam int DIST_SQ_BITS  = 24;
    localparam int US_BITS       = 26;

    localparam logic [9:0] US_PER_MS = 10'd1000;

    // Reset values of the derived threshold registers.
    localparam logic [DIST_SQ_BITS-1:0] RST_TAP_SQ   = 24'd400;
    localparam logic [DIST_SQ_BITS-1:0] RST_SWIPE_SQ = 24'd1600;
    localparam logic [DIST_SQ_BITS-1:0] RST_LP_SQ    = 24'd400;
    localparam logic [US_BITS-1:0]      RST_TAP_US   = 26'd500000;
    localparam logic [US_BITS-1:0]      RST_LP_US    = 26'd800000;
    localparam logic [11:0]             RST_X_LIM    = 12'd539;
    localparam logic [11:0]             RST_Y_LIM    = 12'd959;

endpackage

### rtl/touch_gesture_recognizer_core.sv
// ----------------------------------------------------------------------------
// Touch gesture recognizer core
// Tracks one finger from touch samples and reports tap, swipe, long press.
// ----------------------------------------------------------------------------
// Usage:
// Touch samples arrive on the input channel (in_valid / in_ready) as one word
// of pressed, raw_x, raw_y and time_us. Gestures leave on the output channel
// (out_valid / out_ready) as one word of gesture code and the start point of
// the touch. A sample produces zero or one result word.
// A sample is taken into an input register, evaluated against the tracking
// state and its result is placed in the output register once that register
// is empty or being taken by the receiver. One sample can be accepted in
// every cycle while the receiver takes results; the rate is set by the single
// state update per cycle of the tracking registers.
// When the receiver stalls with a result pending, the input register still
// fills and in_ready drops only while both registers are occupied.
// Thresholds are to be written on the cfg port only while no sample is in
// flight; the block has no check for it. The squared distances and
// microsecond limits are formed at write time. Reset clears the tracking
// mode to idle, empties both registers and loads the default thresholds.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_core #(
    parameter int COORD_BITS = 12,
    parameter int TIME_BITS  = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_addr,
    input  logic [tgr_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              pressed,
    input  logic [15:0]                       raw_x,
    input  logic [15:0]                       raw_y,
    input  logic [TIME_BITS-1:0]              time_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [2:0]                        gesture,
    output logic [11:0]                       pos_x,
    output logic [11:0]                       pos_y
);

    import tgr_pkg::*;

    localparam int DW   = 2 * COORD_BITS + 1;
    localparam int SW   = (DW > DIST_SQ_BITS) ? DW : DIST_SQ_BITS;
    localparam int CMPW = (TIME_BITS > US_BITS) ? TIME_BITS : US_BITS;

    // Threshold registers.
    logic [DIST_SQ_BITS-1:0] tap_sq_reg;
    logic [DIST_SQ_BITS-1:0] swipe_sq_reg;
    logic [DIST_SQ_BITS-1:0] lp_sq_reg;
    logic [US_BITS-1:0]      tap_us_reg;
    logic [US_BITS-1:0]      lp_us_reg;
    logic [11:0]             x_lim_reg;
    logic [11:0]             y_lim_reg;

    // Input register.
    logic                 s1_valid_reg;
    logic                 s1_pressed_reg;
    logic [15:0]          s1_raw_x_reg;
    logic [15:0]          s1_raw_y_reg;
    logic [TIME_BITS-1:0] s1_time_reg;

    // Tracking state.
    logic [1:0]            mode_reg, mode_next;
    logic [COORD_BITS-1:0] origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0] origin_y_reg, origin_y_next;
    logic [COORD_BITS-1:0] latest_x_reg, latest_x_next;
    logic [COORD_BITS-1:0] latest_y_reg, latest_y_next;
    logic [TIME_BITS-1:0]  press_time_reg, press_time_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [2:0]            gesture_reg, gesture_next;
    logic [COORD_BITS-1:0] pos_x_reg, pos_x_next;
    logic [COORD_BITS-1:0] pos_y_reg, pos_y_next;

    logic                    advance;
    logic                    in_fire;
    logic [DIST_SQ_BITS-1:0] cfg_sq;
    logic [US_BITS-1:0]      cfg_us;
    logic [11:0]             cfg_lim;

    logic [COORD_BITS-1:0]   clamp_x;
    logic [COORD_BITS-1:0]   clamp_y;
    logic [COORD_BITS-1:0]   op_x;
    logic [COORD_BITS-1:0]   op_y;
    logic [COORD_BITS-1:0]   abs_x;
    logic [COORD_BITS-1:0]   abs_y;
    logic                    neg_x;
    logic                    neg_y;
    logic [2*COORD_BITS-1:0] sq_x;
    logic [2*COORD_BITS-1:0] sq_y;
    logic [SW-1:0]           dist_sq;
    logic [TIME_BITS-1:0]    elapsed;
    logic [CMPW-1:0]         elapsed_ext;
    logic                    active;
    logic                    result_valid;
    logic [2:0]              result_code;

    function automatic logic [COORD_BITS-1:0] clamp_coord(
        input logic [15:0] raw,
        input logic [11:0] lim
    );
        logic [14:0] v;
        logic [11:0] c;
        begin
            // Raw values with the top bit set are negative and clamp to zero.
            v = raw[15] ? 15'd0 : raw[14:0];
            if (v > {3'b000, lim})
            begin
                c = lim;
            end
            else
            begin
                c = v[11:0];
            end
            return COORD_BITS'(c);
        end
    endfunction

    // Thresholds are squared or scaled to microseconds as they are written.
    assign cfg_sq  = {12'd0, cfg_wdata[11:0]} * {12'd0, cfg_wdata[11:0]};
    assign cfg_us  = US_BITS'(cfg_wdata) * US_BITS'(US_PER_MS);
    assign cfg_lim = (cfg_wdata[11:0] == 12'd0) ? 12'd0 : cfg_wdata[11:0] - 12'd1;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign clamp_x = clamp_coord(s1_raw_x_reg, x_lim_reg);
    assign clamp_y = clamp_coord(s1_raw_y_reg, y_lim_reg);

    // One distance unit serves both the hold check and the release check.
    assign op_x  = s1_pressed_reg ? clamp_x : latest_x_reg;
    assign op_y  = s1_pressed_reg ? clamp_y : latest_y_reg;
    assign neg_x = op_x < origin_x_reg;
    assign neg_y = op_y < origin_y_reg;
    assign abs_x = neg_x ? origin_x_reg - op_x : op_x - origin_x_reg;
    assign abs_y = neg_y ? origin_y_reg - op_y : op_y - origin_y_reg;
    assign sq_x  = abs_x * abs_x;
    assign sq_y  = abs_y * abs_y;
    assign dist_sq = SW'(sq_x) + SW'(sq_y);

    assign elapsed     = s1_time_reg - press_time_reg;
    assign elapsed_ext = CMPW'(elapsed);
    assign active      = (mode_reg == MODE_TRACK) || (mode_reg == MODE_FIRED);

    always_comb
    begin
        mode_next       = mode_reg;
        origin_x_next   = origin_x_reg;
        origin_y_next   = origin_y_reg;
        latest_x_next   = latest_x_reg;
        latest_y_next   = latest_y_reg;
        press_time_next = press_time_reg;
        result_valid    = 1'b0;
        result_code     = GEST_TAP;

        if (s1_pressed_reg)
        begin
            if (!active)
            begin
                mode_next       = MODE_TRACK;
                origin_x_next   = clamp_x;
                origin_y_next   = clamp_y;
                latest_x_next   = clamp_x;
                latest_y_next   = clamp_y;
                press_time_next = s1_time_reg;
            end
            else
            begin
                latest_x_next = clamp_x;
                latest_y_next = clamp_y;
                if ((mode_reg == MODE_TRACK) && (elapsed_ext >= CMPW'(lp_us_reg))
                    && (dist_sq < SW'(lp_sq_reg)))
                begin
                    mode_next    = MODE_FIRED;
                    result_valid = 1'b1;
                    result_code  = GEST_LONG_PRESS;
                end
            end
        end
        else
        begin
            mode_next = MODE_IDLE;
            if (mode_reg == MODE_TRACK)
            begin
                if (dist_sq >= SW'(swipe_sq_reg))
                begin
                    result_valid = 1'b1;
                    // Ties between the axes count as horizontal.
                    if (abs_x >= abs_y)
                    begin
                        result_code = neg_x ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
                    end
                    else
                    begin
                        result_code = neg_y ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
                    end
                end
                else if ((dist_sq < SW'(tap_sq_reg)) && (elapsed_ext < CMPW'(tap_us_reg)))
                begin
                    // Whole milliseconds below the limit is the same as
                    // microseconds below the limit times one thousand.
                    result_valid = 1'b1;
                    result_code  = GEST_TAP;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        gesture_next   = gesture_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        if (advance)
        begin
            out_valid_next = result_valid;
            gesture_next   = result_code;
            pos_x_next     = origin_x_reg;
            pos_y_next     = origin_y_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_sq_reg   <= RST_TAP_SQ;
            swipe_sq_reg <= RST_SWIPE_SQ;
            lp_sq_reg    <= RST_LP_SQ;
            tap_us_reg   <= RST_TAP_US;
            lp_us_reg    <= RST_LP_US;
            x_lim_reg    <= RST_X_LIM;
            y_lim_reg    <= RST_Y_LIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TAP_MAX_DIST:    tap_sq_reg   <= cfg_sq;
                REG_TAP_MAX_TIME_MS: tap_us_reg   <= cfg_us;
                REG_SWIPE_MIN_DIST:  swipe_sq_reg <= cfg_sq;
                REG_LONG_PRESS_MS:   lp_us_reg    <= cfg_us;
                REG_LONG_PRESS_DIST: lp_sq_reg    <= cfg_sq;
                REG_SCREEN_WIDTH:    x_lim_reg    <= cfg_lim;
                REG_SCREEN_HEIGHT:   y_lim_reg    <= cfg_lim;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_IDLE;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            latest_x_reg   <= '0;
            latest_y_reg   <= '0;
            press_time_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg       <= mode_next;
                origin_x_reg   <= origin_x_next;
                origin_y_reg   <= origin_y_next;
                latest_x_reg   <= latest_x_next;
                latest_y_reg   <= latest_y_next;
                press_time_reg <= press_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gesture_reg <= gesture_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        if (in_fire)
        begin
            s1_pressed_reg <= pressed;
            s1_raw_x_reg   <= raw_x;
            s1_raw_y_reg   <= raw_y;
            s1_time_reg    <= time_us;
        end
    end

    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;
    assign pos_x     = 12'(pos_x_reg);
    assign pos_y     = 12'(pos_y_reg);

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch gesture recognizer core testbench
// Sends touch samples with random gaps and stalls, predicts each gesture word
// from its own model of the tracking state and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
    import tgr_pkg::*;

    localparam int     IDLE_LIMIT   = 2000;
    localparam int     DRAIN_CYCLES = 6;
    localparam longint USEC_PER_MS  = 1000;

    typedef struct packed {
        logic [2:0]  code;
        logic [11:0] x;
        logic [11:0] y;
    } gesture_word_t;

    typedef enum int {TOUCH_TAP, TOUCH_SWIPE, TOUCH_HOLD, TOUCH_WANDER, TOUCH_NOISE} touch_kind_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [2:0]               cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic                     pressed   = 1'b0;
    logic [15:0]              raw_x     = '0;
    logic [15:0]              raw_y     = '0;
    logic [31:0]              time_us   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [2:0]               gesture;
    logic [11:0]              pos_x;
    logic [11:0]              pos_y;

    // Thresholds as the block holds them, starting from their reset values.
    logic [11:0] lim_tap_dist   = 12'd20;
    logic [15:0] lim_tap_ms     = 16'd500;
    logic [11:0] lim_swipe_dist = 12'd40;
    logic [15:0] lim_lp_ms      = 16'd800;
    logic [11:0] lim_lp_dist    = 12'd20;
    logic [11:0] scr_w          = 12'd540;
    logic [11:0] scr_h          = 12'd960;

    // Tracking state of the predictor.
    logic [1:0]  track_mode = MODE_IDLE;
    logic [11:0] start_x    = '0;
    logic [11:0] start_y    = '0;
    logic [11:0] last_x     = '0;
    logic [11:0] last_y     = '0;
    logic [31:0] start_us   = '0;

    gesture_word_t gesture_q[$];
    gesture_word_t seen_word;
    gesture_word_t want_word;

    logic [31:0] now_us;
    bit          jitter = 1'b1;
    int          sample_count = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          ready_left = 0;
    int          ready_roll;

    touch_gesture_recognizer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pressed   (pressed),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gesture   (gesture),
        .pos_x     (pos_x),
        .pos_y     (pos_y)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Gesture predictor
    // ------------------------------------------------------------------------
    function automatic logic [11:0] clamp_axis(input logic [15:0] raw, input logic [11:0] size);
        logic [11:0] lim;
        logic [15:0] v;
        lim = (size == 12'd0) ? 12'd0 : size - 12'd1;
        v = raw[15] ? 16'd0 : raw;
        if (v > {4'd0, lim})
        begin
            v = {4'd0, lim};
        end
        return v[11:0];
    endfunction

    // Updates the tracking state for one sample and queues the gesture it
    // causes. Returns 0 only for a release that an idle tracker ignores.
    function automatic bit track_sample(input logic p, input logic [15:0] rx,
                                        input logic [15:0] ry, input logic [31:0] t);
        logic [11:0] cx;
        logic [11:0] cy;
        logic [31:0] held_us;
        logic [2:0]  code;
        longint      dx;
        longint      dy;
        longint      dsq;
        bit          active;
        held_us = t - start_us;
        active = (track_mode == MODE_TRACK) || (track_mode == MODE_FIRED);
        if (p)
        begin
            cx = clamp_axis(rx, scr_w);
            cy = clamp_axis(ry, scr_h);
            last_x = cx;
            last_y = cy;
            if (!active)
            begin
                track_mode = MODE_TRACK;
                start_x = cx;
                start_y = cy;
                start_us = t;
                return 1'b1;
            end
            if (track_mode == MODE_TRACK)
            begin
                dx = longint'(cx) - longint'(start_x);
                dy = longint'(cy) - longint'(start_y);
                dsq = dx * dx + dy * dy;
                if (longint'(held_us) >= longint'(lim_lp_ms) * USEC_PER_MS &&
                    dsq < longint'(lim_lp_dist) * longint'(lim_lp_dist))
                begin
                    gesture_q.push_back(gesture_word_t'{GEST_LONG_PRESS, start_x, start_y});
                    track_mode = MODE_FIRED;
                end
            end
            return 1'b1;
        end
        // A release ends tracking; only a touch still being tracked reports.
        if (track_mode != MODE_TRACK)
        begin
            track_mode = MODE_IDLE;
            return active;
        end
        track_mode = MODE_IDLE;
        dx = longint'(last_x) - longint'(start_x);
        dy = longint'(last_y) - longint'(start_y);
        dsq = dx * dx + dy * dy;
        if (dsq >= longint'(lim_swipe_dist) * longint'(lim_swipe_dist))
        begin
            if (((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy))
            begin
                code = (dx < 0) ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
            end
            else
            begin
                code = (dy < 0) ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
            end
            gesture_q.push_back(gesture_word_t'{code, start_x, start_y});
        end
        else if (dsq < longint'(lim_tap_dist) * longint'(lim_tap_dist) &&
                 longint'(held_us) / USEC_PER_MS < longint'(lim_tap_ms))
        begin
            gesture_q.push_back(gesture_word_t'{GEST_TAP, start_x, start_y});
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        if (!jitter)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_sample(input logic p, input logic [15:0] rx, input logic [15:0] ry,
                               input logic [31:0] t);
        int gap;
        bit took;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (track_sample(p, rx, ry, t))
        begin
            sample_count++;
        end
        in_valid <= 1'b1;
        pressed  <= p;
        raw_x    <= rx;
        raw_y    <= ry;
        time_us  <= t;
        took = 1'b0;
        // Handshake signals are sampled at the falling edge ahead of the rising edge.
        while (!took)
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (gesture_q.size() != 0)
        begin
            @(posedge clk);
        end
        // Samples that cause no word may still sit in the pipeline.
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_TAP_MAX_DIST:    lim_tap_dist   = value[11:0];
            REG_TAP_MAX_TIME_MS: lim_tap_ms     = value;
            REG_SWIPE_MIN_DIST:  lim_swipe_dist = value[11:0];
            REG_LONG_PRESS_MS:   lim_lp_ms      = value;
            REG_LONG_PRESS_DIST: lim_lp_dist    = value[11:0];
            REG_SCREEN_WIDTH:    scr_w          = value[11:0];
            REG_SCREEN_HEIGHT:   scr_h          = value[11:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_thresholds(input int tap_dist, input int tap_ms, input int swipe_dist,
                                   input int lp_ms, input int lp_dist, input int width,
                                   input int height);
        drain_results();
        write_reg(REG_TAP_MAX_DIST, 16'(tap_dist));
        write_reg(REG_TAP_MAX_TIME_MS, 16'(tap_ms));
        write_reg(REG_SWIPE_MIN_DIST, 16'(swipe_dist));
        write_reg(REG_LONG_PRESS_MS, 16'(lp_ms));
        write_reg(REG_LONG_PRESS_DIST, 16'(lp_dist));
        write_reg(REG_SCREEN_WIDTH, 16'(width));
        write_reg(REG_SCREEN_HEIGHT, 16'(height));
        cfg_we <= 1'b0;
    endtask

    // A negative coordinate is sent as a controller value with the top bit set.
    function automatic logic [15:0] raw_of(input int v);
        if (v < 0)
        begin
            return 16'h8000 | 16'($urandom_range(0, 32767));
        end
        if (v > 32767)
        begin
            return 16'h7FFF;
        end
        return 16'(v);
    endfunction

    function automatic int rand_off(input int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] wander_step();
        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom;
        end
        return $urandom_range(1, 1500000);
    endfunction

    task automatic touch_at(input logic p, input int x, input int y, input logic [31:0] dt);
        now_us = now_us + dt;
        send_sample(p, raw_of(x), raw_of(y), now_us);
    endtask

    // One touch, usually from press to release, with random content, or one random noise sample.
    task automatic send_touch(input touch_kind_t kind);
        int          wmax;
        int          hmax;
        int          sx;
        int          sy;
        int          x;
        int          y;
        int          span;
        int          mag;
        int          side;
        int          steps;
        int          roll;
        logic [31:0] hold_step;
        logic [31:0] lift_us;
        if (kind == TOUCH_NOISE)
        begin
            send_sample(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), $urandom);
            return;
        end
        wmax = (scr_w == 12'd0) ? 0 : int'(scr_w) - 1;
        hmax = (scr_h == 12'd0) ? 0 : int'(scr_h) - 1;
        sx = $urandom_range(0, wmax + wmax / 8 + 2) - wmax / 16 - 1;
        sy = $urandom_range(0, hmax + hmax / 8 + 2) - hmax / 16 - 1;
        touch_at(1'b1, sx, sy, $urandom_range(1, 5000));
        case (kind)
            TOUCH_TAP:
            begin
                span = int'(lim_tap_dist) / 2;
                steps = $urandom_range(0, 2);
                repeat (steps)
                begin
                    touch_at(1'b1, sx + rand_off(span), sy + rand_off(span),
                             $urandom_range(1, int'(lim_tap_ms) * 250 + 1));
                end
                lift_us = $urandom_range(1, int'(lim_tap_ms) * 250 + 1);
            end
            TOUCH_SWIPE:
            begin
                mag = int'(lim_swipe_dist) + $urandom_range(0, int'(lim_swipe_dist) + 20);
                side = rand_off(mag);
                x = sx + side;
                y = sy + side;
                case ($urandom_range(0, 3))
                    0: x = sx - mag;
                    1: x = sx + mag;
                    2: y = sy - mag;
                    default: y = sy + mag;
                endcase
                steps = $urandom_range(0, 2);
                for (int i = 1; i <= steps; i++)
                begin
                    touch_at(1'b1, sx + (x - sx) * i / (steps + 1), sy + (y - sy) * i / (steps + 1),
                             $urandom_range(1, 80000));
                end
                touch_at(1'b1, x, y, $urandom_range(1, 80000));
                lift_us = $urandom_range(1, 80000);
            end
            TOUCH_HOLD:
            begin
                span = int'(lim_lp_dist) / 2;
                steps = $urandom_range(2, 5);
                hold_step = int'(lim_lp_ms) * 400 + $urandom_range(1, 20000);
                repeat (steps)
                begin
                    touch_at(1'b1, sx + rand_off(span), sy + rand_off(span), hold_step);
                end
                lift_us = $urandom_range(1, 20000);
            end
            default:
            begin
                steps = $urandom_range(0, 5);
                repeat (steps)
                begin
                    touch_at(1'b1, sx + rand_off(300), sy + rand_off(300), wander_step());
                end
                lift_us = wander_step();
            end
        endcase
        // Mostly a clean release; sometimes none, sometimes a second one.
        roll = $urandom_range(0, 19);
        if (roll != 0)
        begin
            touch_at(1'b0, $urandom_range(0, 70000) - 2000, $urandom_range(0, 70000) - 2000,
                     lift_us);
        end
        if (roll == 1)
        begin
            touch_at(1'b0, sx, sy, $urandom_range(1, 1000));
        end
    endtask

    function automatic touch_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
        begin
            return TOUCH_TAP;
        end
        if (roll < 50)
        begin
            return TOUCH_SWIPE;
        end
        if (roll < 70)
        begin
            return TOUCH_HOLD;
        end
        if (roll < 88)
        begin
            return TOUCH_WANDER;
        end
        return TOUCH_NOISE;
    endfunction

    function automatic int pick_level(input int lo, input int hi, input int top);
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            return 0;
        end
        if (roll == 1)
        begin
            return top;
        end
        return $urandom_range(lo, hi);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver stalls and result checking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!jitter)
        begin
            out_ready <= 1'b1;
            ready_left = 0;
        end
        else if (ready_left > 0)
        begin
            ready_left--;
        end
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60)
            begin
                out_ready <= 1'b1;
                ready_left = $urandom_range(0, 8);
            end
            else if (ready_roll < 93)
            begin
                out_ready <= 1'b0;
                ready_left = $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                ready_left = $urandom_range(15, 40);
            end
        end
    end

    // A word seen valid and ready here is taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_word = gesture_word_t'{gesture, pos_x, pos_y};
            if (gesture_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected gesture word: code %0d at (%0d, %0d)",
                             gesture, pos_x, pos_y);
                end
            end
            else
            begin
                want_word = gesture_q.pop_front();
                if (seen_word.code !== want_word.code || seen_word.x !== want_word.x ||
                    seen_word.y !== want_word.y)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display({"gesture word differs: expected code %0d at (%0d, %0d), ",
                                  "got code %0d at (%0d, %0d)"},
                                 want_word.code, want_word.x, want_word.y,
                                 seen_word.code, seen_word.x, seen_word.y);
                    end
                end
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_gestures();
        // Release with nothing being tracked.
        send_sample(1'b0, 16'd100, 16'd100, 32'd1000);
        // Tap whose timestamps wrap around.
        send_sample(1'b1, 16'd100, 16'd200, 32'hFFFF_FF00);
        send_sample(1'b0, 16'd0, 16'd0, 32'h0001_0000);
        // Swipe left with equal axes.
        send_sample(1'b1, 16'd300, 16'd500, 32'd1000000);
        send_sample(1'b1, 16'd250, 16'd450, 32'd1050000);
        send_sample(1'b0, 16'hFFFF, 16'hFFFF, 32'd1100000);
        // Swipe right from a negative x to a point past the screen edge.
        send_sample(1'b1, 16'h8000, 16'd400, 32'd2000000);
        send_sample(1'b1, 16'h7FFF, 16'd420, 32'd2100000);
        send_sample(1'b0, 16'd0, 16'd0, 32'd2150000);
        send_sample(1'b1, 16'd200, 16'd700, 32'd3000000);
        send_sample(1'b1, 16'd210, 16'd640, 32'd3050000);
        send_sample(1'b0, 16'd210, 16'd640, 32'd3100000);
        send_sample(1'b1, 16'd200, 16'hFFFF, 32'd4000000);
        send_sample(1'b1, 16'd200, 16'd5000, 32'd4100000);
        send_sample(1'b0, 16'd200, 16'd5000, 32'd4150000);
        // Long press, a later move that must not fire again, silent release.
        send_sample(1'b1, 16'd400, 16'd400, 32'd5000000);
        send_sample(1'b1, 16'd405, 16'd402, 32'd5900000);
        send_sample(1'b1, 16'd480, 16'd480, 32'd6000000);
        send_sample(1'b0, 16'd480, 16'd480, 32'd6050000);
        // A move too far for a tap and too short for a swipe.
        send_sample(1'b1, 16'd100, 16'd100, 32'd7000000);
        send_sample(1'b1, 16'd130, 16'd100, 32'd7100000);
        send_sample(1'b0, 16'd130, 16'd100, 32'd7150000);
        // Held too long for a tap, with no sample during the hold so no long press.
        send_sample(1'b1, 16'd50, 16'd50, 32'd8000000);
        send_sample(1'b0, 16'd50, 16'd50, 32'd8600000);
    endtask

    task automatic test_threshold_extremes();
        load_thresholds(4095, 65535, 4095, 65535, 4095, 4095, 4095);
        send_sample(1'b1, 16'd0, 16'd0, 32'd100);
        send_sample(1'b1, 16'd4094, 16'd4094, 32'd200);
        send_sample(1'b0, 16'd0, 16'd0, 32'd300);
        send_sample(1'b1, 16'd10, 16'd10, 32'd400);
        send_sample(1'b0, 16'd10, 16'd10, 32'd500);
        // Zero screen size pins both coordinates to zero.
        load_thresholds(0, 0, 0, 0, 0, 0, 0);
        send_sample(1'b1, 16'd300, 16'd300, 32'hFFFF_FFFF);
        send_sample(1'b1, 16'd1000, 16'd5, 32'd0);
        send_sample(1'b0, 16'd0, 16'd0, 32'd10);
        load_thresholds(4095, 1, 4095, 0, 4095, 1, 4095);
        send_sample(1'b1, 16'd1, 16'd1, 32'd1000);
        send_sample(1'b1, 16'd9, 16'd4000, 32'd1000);
        send_sample(1'b0, 16'd9, 16'd4000, 32'd1001);
        send_sample(1'b1, 16'd3, 16'd3, 32'd2000);
        send_sample(1'b0, 16'd3, 16'd3, 32'd2999);
    endtask

    task automatic test_random_touches();
        int phase_goal;
        now_us = $urandom;
        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
            begin
                load_thresholds(20, 500, 40, 800, 20, 540, 960);
            end
            else
            begin
                load_thresholds(pick_level(5, 60, 4095), pick_level(100, 1000, 65535),
                                pick_level(20, 200, 4095), pick_level(200, 1500, 65535),
                                pick_level(5, 60, 4095), pick_level(100, 4095, 4095),
                                pick_level(100, 4095, 4095));
            end
            jitter = (phase % 3) != 1;
            phase_goal = sample_count + 60;
            while (sample_count < phase_goal)
            begin
                send_touch(pick_kind());
            end
        end
        drain_results();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_gestures();
        test_threshold_extremes();
        test_random_touches();
        if (mismatches == 0 && gesture_q.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
